// ----- rtl/mcl_pkg.sv -----
// Package with the shared constants and widths of the mip chain layout generator.
`timescale 1ns / 1ps

package mcl_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 44;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DEPTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES    = 3'd7;

  localparam logic [1:0] MODE_LINEAR   = 2'd0;
  localparam logic [1:0] MODE_BLOCK_8  = 2'd1;

  localparam int unsigned DIM_W    = 15;
  localparam int unsigned DEPTH_W  = 12;
  localparam int unsigned MIP_W    = 4;
  localparam int unsigned SLICE_W  = 11;
  localparam int unsigned COUNT_W  = 12;
  localparam int unsigned BPP_W    = 8;
  localparam int unsigned TOTAL_W  = 44;
  localparam int unsigned ROW_W    = 20;
  localparam int unsigned BYTES_W  = 35;
  localparam int unsigned ADD_W    = 47;
  localparam int unsigned PITCH_W  = 19;
  localparam int unsigned LEVEL_W  = 33;

  localparam int unsigned MUL_A_W  = 35;
  localparam int unsigned MUL_B_W  = 15;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

  localparam logic [COUNT_W-1:0] MAX_SLICES = 12'd2048;

endpackage

// ----- rtl/mip_chain_layout_generator.sv -----
// Top level of the mip chain layout generator: walk state, sequencer and output register.
`timescale 1ns / 1ps

// Usage:
// Each beat on the input channel (in_valid, in_stall, in_restart) produces one
// beat on the output channel with the layout of the next subresource of the
// texture, walking slice by slice and mip by mip. in_restart set starts again
// at slice 0, mip 0, offset 0. After the beat marked last the walk restarts.
// Registers are written on the cfg channel (cfg_ready is always high); the user
// must write them only while the block is idle, which the block does not enforce.
// cfg_index selects the register. Each beat takes three passes through one
// shared registered multiplier (row bytes, bytes per depth slice, bytes times
// depth) and an add and compare step, in ST_ROW, ST_BYTES, ST_ADD and ST_END.
// in_stall is high while a beat is in work.
// The result sits in an output register; if the receiver holds out_stall,
// the next beat is still accepted and waits in its final cycle until the
// output register frees. Synchronous reset restores register defaults,
// clears the walk position and drops out_valid.
module mip_chain_layout_generator import mcl_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 44
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_restart,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SLICE_W-1:0]     out_slice_index,
  output logic [MIP_W-1:0]       out_mip_index,
  output logic [OFFSET_BITS-1:0] out_start_offset,
  output logic [LEVEL_W-1:0]     out_level_bytes,
  output logic [PITCH_W-1:0]     out_row_pitch,
  output logic [LEVEL_W-1:0]     out_depth_pitch,
  output logic                   out_overflow,
  output logic                   out_last
);

  localparam int unsigned END_W = ((OFFSET_BITS > ADD_W) ? OFFSET_BITS : ADD_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_BYTES,
    ST_ADD,
    ST_END
  } state_t;

  state_t state_r;

  logic [1:0]             block_mode_r;
  logic [BPP_W-1:0]       bits_per_pixel_r;
  logic [DIM_W-1:0]       base_width_r;
  logic [DIM_W-1:0]       base_height_r;
  logic [DEPTH_W-1:0]     base_depth_r;
  logic [MIP_W-1:0]       level_count_r;
  logic [COUNT_W-1:0]     slice_count_r;
  logic [TOTAL_W-1:0]     total_bytes_r;

  logic [DIM_W-1:0]       cur_width_r;
  logic [DIM_W-1:0]       cur_height_r;
  logic [DEPTH_W-1:0]     cur_depth_r;
  logic [MIP_W-1:0]       cur_mip_r;
  logic [SLICE_W-1:0]     cur_slice_r;
  logic [OFFSET_BITS-1:0] running_offset_r;

  logic [ROW_W-1:0]       row_r;
  logic [BYTES_W-1:0]     bytes_r;

  logic [MUL_A_W-1:0]     op_a;
  logic [MUL_B_W-1:0]     op_b;
  logic [PROD_W-1:0]      prod_r;

  logic                   linear;
  logic [DIM_W-2:0]       blocks_w;
  logic [DIM_W-2:0]       blocks_h;
  logic [DIM_W-1:0]       rows;
  logic [23:0]            lin_sum;
  logic [ROW_W-1:0]       row_calc;
  logic [END_W-1:0]       end_sum;
  logic                   over;
  logic [MIP_W-1:0]       levels;
  logic [COUNT_W-1:0]     slices;
  logic                   mip_final;
  logic                   is_last;
  logic                   in_beat;
  logic                   out_free;
  logic [DIM_W-1:0]       half_w;
  logic [DIM_W-1:0]       half_h;
  logic [DEPTH_W-1:0]     half_d;
  logic [DIM_W:0]         w_round;
  logic [DIM_W:0]         h_round;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign linear   = (block_mode_r == MODE_LINEAR);
  assign w_round  = {1'b0, cur_width_r} + (DIM_W + 1)'(3);
  assign h_round  = {1'b0, cur_height_r} + (DIM_W + 1)'(3);
  assign blocks_w = w_round[DIM_W:2];
  assign blocks_h = h_round[DIM_W:2];
  assign rows     = linear ? cur_height_r : {1'b0, blocks_h};
  assign lin_sum  = {1'b0, prod_r[22:0]} + 24'd7;
  assign row_calc = linear ? lin_sum[22:3] : prod_r[ROW_W-1:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_ROW: begin
        if (linear) begin
          op_a = MUL_A_W'(cur_width_r);
          op_b = MUL_B_W'(bits_per_pixel_r);
        end else begin
          op_a = MUL_A_W'(blocks_w);
          op_b = (block_mode_r == MODE_BLOCK_8) ? MUL_B_W'(8) : MUL_B_W'(16);
        end
      end
      ST_BYTES: begin
        op_a = MUL_A_W'(row_calc);
        op_b = rows;
      end
      ST_ADD: begin
        op_a = prod_r[BYTES_W-1:0];
        op_b = MUL_B_W'(cur_depth_r);
      end
      ST_END: begin
        // The product is recomputed so that it holds while the result waits.
        op_a = bytes_r;
        op_b = MUL_B_W'(cur_depth_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  mcl_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign end_sum = END_W'(running_offset_r) + END_W'(prod_r[ADD_W-1:0]);
  assign over    = (|end_sum[END_W-1:OFFSET_BITS]) || (end_sum > END_W'(total_bytes_r));

  assign levels    = (level_count_r == '0) ? MIP_W'(1) : level_count_r;
  assign slices    = (slice_count_r == '0) ? COUNT_W'(1) :
                     (slice_count_r > MAX_SLICES) ? MAX_SLICES : slice_count_r;
  assign mip_final = ({1'b0, cur_mip_r} + (MIP_W + 1)'(1)) >= {1'b0, levels};
  assign is_last   = mip_final &&
                     ((COUNT_W'(cur_slice_r) + COUNT_W'(1)) >= slices);

  assign half_w = (cur_width_r[DIM_W-1:1] == '0) ? DIM_W'(1) : {1'b0, cur_width_r[DIM_W-1:1]};
  assign half_h = (cur_height_r[DIM_W-1:1] == '0) ? DIM_W'(1) :
                  {1'b0, cur_height_r[DIM_W-1:1]};
  assign half_d = (cur_depth_r[DEPTH_W-1:1] == '0) ? DEPTH_W'(1) :
                  {1'b0, cur_depth_r[DEPTH_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_mode_r     <= MODE_LINEAR;
      bits_per_pixel_r <= BPP_W'(32);
      base_width_r     <= DIM_W'(1);
      base_height_r    <= DIM_W'(1);
      base_depth_r     <= DEPTH_W'(1);
      level_count_r    <= MIP_W'(1);
      slice_count_r    <= COUNT_W'(1);
      total_bytes_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLOCK_MODE:     block_mode_r     <= cfg_data[1:0];
        CFG_BITS_PER_PIXEL: bits_per_pixel_r <= cfg_data[BPP_W-1:0];
        CFG_BASE_WIDTH:     base_width_r     <= cfg_data[DIM_W-1:0];
        CFG_BASE_HEIGHT:    base_height_r    <= cfg_data[DIM_W-1:0];
        CFG_BASE_DEPTH:     base_depth_r     <= cfg_data[DEPTH_W-1:0];
        CFG_LEVEL_COUNT:    level_count_r    <= cfg_data[MIP_W-1:0];
        CFG_SLICE_COUNT:    slice_count_r    <= cfg_data[COUNT_W-1:0];
        CFG_TOTAL_BYTES:    total_bytes_r    <= cfg_data[TOTAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid        <= 1'b0;
      cur_width_r      <= '0;
      cur_height_r     <= '0;
      cur_depth_r      <= '0;
      cur_mip_r        <= '0;
      cur_slice_r      <= '0;
      running_offset_r <= '0;
    end else begin
      if (out_valid && !out_stall && state_r != ST_END) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            if (in_restart) begin
              cur_slice_r      <= '0;
              cur_mip_r        <= '0;
              running_offset_r <= '0;
            end
            if (in_restart || cur_mip_r == '0) begin
              cur_width_r  <= base_width_r;
              cur_height_r <= base_height_r;
              cur_depth_r  <= base_depth_r;
            end
            state_r <= ST_ROW;
          end
        end
        ST_ROW: begin
          state_r <= ST_BYTES;
        end
        ST_BYTES: begin
          row_r   <= row_calc;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          bytes_r <= prod_r[BYTES_W-1:0];
          state_r <= ST_END;
        end
        ST_END: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_slice_index  <= cur_slice_r;
            out_mip_index    <= cur_mip_r;
            out_start_offset <= running_offset_r;
            out_level_bytes  <= bytes_r[LEVEL_W-1:0];
            out_row_pitch    <= row_r[PITCH_W-1:0];
            out_depth_pitch  <= bytes_r[LEVEL_W-1:0];
            out_overflow     <= over;
            out_last         <= is_last;
            if (is_last) begin
              cur_slice_r      <= '0;
              cur_mip_r        <= '0;
              running_offset_r <= '0;
            end else begin
              running_offset_r <= end_sum[OFFSET_BITS-1:0];
              if (mip_final) begin
                cur_mip_r   <= '0;
                cur_slice_r <= cur_slice_r + SLICE_W'(1);
              end else begin
                cur_mip_r    <= cur_mip_r + MIP_W'(1);
                cur_width_r  <= half_w;
                cur_height_r <= half_h;
                cur_depth_r  <= half_d;
              end
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> in_stall)
    else $error("Block did not hold off input after accepting a beat.");

  a_mip_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mip_index != 4'hF))
    else $error("Mip index left the legal range.");

  a_pitch_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_depth_pitch == out_level_bytes))
    else $error("Depth pitch and level bytes disagree.");

  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_END && out_free && is_last) |=>
      (cur_mip_r == '0 && cur_slice_r == '0 && running_offset_r == '0))
    else $error("Walk position not cleared after the final subresource.");
`endif

endmodule

// ----- rtl/mcl_mul.sv -----
// Shared registered multiplier used for every product of the layout computation.
`timescale 1ns / 1ps

module mcl_mul import mcl_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

// ----- bench/tb_mip_chain_layout_generator.sv -----
// Self-checking testbench for the mip chain layout generator, with its own layout predictor.
`timescale 1ns / 1ps

module tb_mip_chain_layout_generator;
  import mcl_pkg::*;

  localparam int unsigned OFF_W = 44;
  localparam logic [63:0] OFF_MASK = (64'd1 << OFF_W) - 64'd1;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES = 12;
  localparam int unsigned BEATS_PER_PHASE = 125;
  localparam int unsigned TABLE_ROWS = 45;

  typedef struct packed {
    logic [SLICE_W-1:0] slice_index;
    logic [MIP_W-1:0]   mip_index;
    logic [OFF_W-1:0]   start_offset;
    logic [LEVEL_W-1:0] level_bytes;
    logic [PITCH_W-1:0] row_pitch;
    logic [LEVEL_W-1:0] depth_pitch;
    logic               overflow;
    logic               last;
  } layout_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  restart;
    logic                  typed;
    layout_t               want;
  } step_row_t;

  localparam layout_t UNCHECKED = '0;
  localparam logic [1:0] MODE_BLOCK_16 = 2'd2;
  localparam logic [1:0] MODE_BLOCK_16_ALIAS = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SLICE_W-1:0] out_slice_index;
  logic [MIP_W-1:0] out_mip_index;
  logic [OFF_W-1:0] out_start_offset;
  logic [LEVEL_W-1:0] out_level_bytes;
  logic [PITCH_W-1:0] out_row_pitch;
  logic [LEVEL_W-1:0] out_depth_pitch;
  logic out_overflow;
  logic out_last;

  logic [1:0] cfg_mode = MODE_LINEAR;
  logic [BPP_W-1:0] cfg_bpp = 8'd32;
  logic [DIM_W-1:0] cfg_width = 15'd1;
  logic [DIM_W-1:0] cfg_height = 15'd1;
  logic [DEPTH_W-1:0] cfg_depth = 12'd1;
  logic [MIP_W-1:0] cfg_levels = 4'd1;
  logic [COUNT_W-1:0] cfg_slices = 12'd1;
  logic [TOTAL_W-1:0] cfg_total = '0;

  logic [63:0] lay_w = '0;
  logic [63:0] lay_h = '0;
  logic [63:0] lay_d = '0;
  logic [63:0] lay_mip = '0;
  logic [63:0] lay_slice = '0;
  logic [63:0] lay_off = '0;

  layout_t pending_layouts [$];
  layout_t want;
  int mismatches = 0;
  int send_idle = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  step_row_t directed [TABLE_ROWS] = '{
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b1,
      '{11'd0, 4'd0, 44'd0, 33'd4, 19'd4, 33'd4, 1'b1, 1'b1}},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b1, 1'b1,
      '{11'd0, 4'd0, 44'd0, 33'd4, 19'd4, 33'd4, 1'b1, 1'b1}},
    '{ROW_CFG, CFG_TOTAL_BYTES, 44'd4, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b1,
      '{11'd0, 4'd0, 44'd0, 33'd4, 19'd4, 33'd4, 1'b0, 1'b1}},
    '{ROW_CFG, CFG_BITS_PER_PIXEL, 44'd1, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b1, 1'b1,
      '{11'd0, 4'd0, 44'd0, 33'd1, 19'd1, 33'd1, 1'b0, 1'b1}},
    '{ROW_CFG, CFG_BITS_PER_PIXEL, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b1,
      '{11'd0, 4'd0, 44'd0, 33'd0, 19'd0, 33'd0, 1'b0, 1'b1}},
    '{ROW_CFG, CFG_BITS_PER_PIXEL, 44'd255, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BASE_WIDTH, 44'd32767, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BASE_HEIGHT, 44'd32767, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BASE_DEPTH, 44'd4095, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_LEVEL_COUNT, 44'd15, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_SLICE_COUNT, 44'd4095, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_TOTAL_BYTES, 44'hFFF_FFFF_FFFF, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b1, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BLOCK_MODE, 44'(MODE_BLOCK_16_ALIAS), 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BASE_WIDTH, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BASE_HEIGHT, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BASE_DEPTH, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_LEVEL_COUNT, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_SLICE_COUNT, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_TOTAL_BYTES, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b1, 1'b1,
      '{11'd0, 4'd0, 44'd0, 33'd0, 19'd0, 33'd0, 1'b0, 1'b1}},
    '{ROW_CFG, CFG_BLOCK_MODE, 44'(MODE_BLOCK_8), 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BASE_WIDTH, 44'd5, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BASE_HEIGHT, 44'd5, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BASE_DEPTH, 44'd2, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_LEVEL_COUNT, 44'd3, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_SLICE_COUNT, 44'd2, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_TOTAL_BYTES, 44'd100, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b1, 1'b1,
      '{11'd0, 4'd0, 44'd0, 33'd32, 19'd16, 33'd32, 1'b0, 1'b0}},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_LEVEL_COUNT, 44'd1, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED},
    '{ROW_CFG, CFG_BLOCK_MODE, 44'(MODE_BLOCK_16), 1'b0, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b1, 1'b0, UNCHECKED},
    '{ROW_ITEM, CFG_BLOCK_MODE, 44'd0, 1'b0, 1'b0, UNCHECKED}
  };

  mip_chain_layout_generator #(.OFFSET_BITS(OFF_W)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_slice_index(out_slice_index),
    .out_mip_index(out_mip_index),
    .out_start_offset(out_start_offset),
    .out_level_bytes(out_level_bytes),
    .out_row_pitch(out_row_pitch),
    .out_depth_pitch(out_depth_pitch),
    .out_overflow(out_overflow),
    .out_last(out_last)
  );

  always #10 clk = ~clk;

  function automatic layout_t next_subresource(input bit restart);
    logic [63:0] levels, slices, row, rows, bytes, add, run_end;
    logic fin;
    layout_t r;
    if (restart) begin
      lay_slice = '0;
      lay_mip = '0;
      lay_off = '0;
    end
    if (lay_mip == 0) begin
      lay_w = 64'(cfg_width);
      lay_h = 64'(cfg_height);
      lay_d = 64'(cfg_depth);
    end
    if (cfg_mode == MODE_LINEAR) begin
      row = (lay_w * 64'(cfg_bpp) + 64'd7) / 64'd8;
      rows = lay_h;
    end else begin
      row = ((lay_w + 64'd3) / 64'd4) * ((cfg_mode == MODE_BLOCK_8) ? 64'd8 : 64'd16);
      rows = (lay_h + 64'd3) / 64'd4;
    end
    bytes = row * rows;
    add = bytes * lay_d;
    run_end = lay_off + add;
    levels = 64'(cfg_levels);
    if (levels == 0) levels = 64'd1;
    slices = 64'(cfg_slices);
    if (slices == 0) slices = 64'd1;
    else if (slices > 64'(MAX_SLICES)) slices = 64'(MAX_SLICES);
    fin = (lay_slice + 64'd1 >= slices) && (lay_mip + 64'd1 >= levels);
    r.slice_index = lay_slice[SLICE_W-1:0];
    r.mip_index = lay_mip[MIP_W-1:0];
    r.start_offset = lay_off[OFF_W-1:0];
    r.level_bytes = bytes[LEVEL_W-1:0];
    r.row_pitch = row[PITCH_W-1:0];
    r.depth_pitch = bytes[LEVEL_W-1:0];
    r.overflow = (run_end > OFF_MASK) || (run_end > 64'(cfg_total));
    r.last = fin;
    if (fin) begin
      lay_slice = '0;
      lay_mip = '0;
      lay_off = '0;
    end else begin
      lay_off = run_end & OFF_MASK;
      if (lay_mip + 64'd1 >= levels) begin
        lay_mip = '0;
        lay_slice = lay_slice + 64'd1;
      end else begin
        lay_mip = lay_mip + 64'd1;
        lay_w = lay_w >> 1;
        lay_h = lay_h >> 1;
        lay_d = lay_d >> 1;
        if (lay_w == 0) lay_w = 64'd1;
        if (lay_h == 0) lay_h = 64'd1;
        if (lay_d == 0) lay_d = 64'd1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_BLOCK_MODE:     cfg_mode = val[1:0];
      CFG_BITS_PER_PIXEL: cfg_bpp = val[BPP_W-1:0];
      CFG_BASE_WIDTH:     cfg_width = val[DIM_W-1:0];
      CFG_BASE_HEIGHT:    cfg_height = val[DIM_W-1:0];
      CFG_BASE_DEPTH:     cfg_depth = val[DEPTH_W-1:0];
      CFG_LEVEL_COUNT:    cfg_levels = val[MIP_W-1:0];
      CFG_SLICE_COUNT:    cfg_slices = val[COUNT_W-1:0];
      default:            cfg_total = val[TOTAL_W-1:0];
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_layouts.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input bit restart, input bit typed, input layout_t typed_want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) begin
      void'(next_subresource(restart));
      pending_layouts.push_back(typed_want);
    end else begin
      pending_layouts.push_back(next_subresource(restart));
    end
  endtask

  // Mostly small textures so that walks finish often; now and then a huge one.
  task automatic retune(input bit every);
    logic [CFG_DATA_W-1:0] val;
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < 8; i++) begin
      idx = CFG_IDX_W'(i);
      case (idx)
        CFG_BLOCK_MODE:     val = CFG_DATA_W'($urandom_range(3));
        CFG_BITS_PER_PIXEL: val = CFG_DATA_W'(($urandom_range(9) < 8) ? $urandom_range(1, 128)
                                                                       : $urandom_range(0, 255));
        CFG_BASE_WIDTH,
        CFG_BASE_HEIGHT:    val = CFG_DATA_W'(($urandom_range(9) < 8) ? $urandom_range(1, 64)
                                                                       : $urandom_range(0, 32767));
        CFG_BASE_DEPTH:     val = CFG_DATA_W'(($urandom_range(9) < 8) ? $urandom_range(1, 8)
                                                                       : $urandom_range(0, 4095));
        CFG_LEVEL_COUNT:    val = CFG_DATA_W'($urandom_range(15));
        CFG_SLICE_COUNT:    val = CFG_DATA_W'(($urandom_range(19) < 17) ? $urandom_range(0, 4)
                                                                         : $urandom_range(0, 4095));
        default: begin
          case ($urandom_range(3))
            0: val = '0;
            1: val = '1;
            2: val = CFG_DATA_W'({$urandom, $urandom});
            default: val = CFG_DATA_W'({$urandom, $urandom} >> $urandom_range(4, 43));
          endcase
        end
      endcase
      if (every || $urandom_range(1)) cfg_write(idx, val);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_layouts.size() == 0) begin
        $error("result beat arrived with no layout pending");
        mismatches++;
      end else begin
        want = pending_layouts.pop_front();
        check_field("slice_index", 64'(want.slice_index), 64'(out_slice_index));
        check_field("mip_index", 64'(want.mip_index), 64'(out_mip_index));
        check_field("start_offset", 64'(want.start_offset), 64'(out_start_offset));
        check_field("level_bytes", 64'(want.level_bytes), 64'(out_level_bytes));
        check_field("row_pitch", 64'(want.row_pitch), 64'(out_row_pitch));
        check_field("depth_pitch", 64'(want.depth_pitch), 64'(out_depth_pitch));
        check_field("overflow", 64'(want.overflow), 64'(out_overflow));
        check_field("last", 64'(want.last), 64'(out_last));
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int restart_pct;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_CFG) begin
        drain();
        cfg_write(directed[k].idx, directed[k].val);
      end else begin
        cfg_valid <= 1'b0;
        send_item(directed[k].restart, directed[k].typed, directed[k].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      retune(phase % 2 == 0);
      cfg_valid <= 1'b0;
      case (phase % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 81; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 81; end
        default: begin send_idle = 36; stall_pct = 36; end
      endcase
      // The receiver holds off while beats keep coming, so the block backs up.
      if (phase == 5) begin
        send_idle = 0;
        stall_pct = 0;
        hold_req = 1'b1;
      end
      restart_pct = $urandom_range(1) ? 3 : 15;
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (phase == 6 && n == BEATS_PER_PHASE / 2) drain();
        send_item($urandom_range(99) < restart_pct, 1'b0, UNCHECKED);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
